// File: design/cnls_pkg.sv
// Shared types, character codes and the clear state of the numeric literal scanner.
package cnls_pkg;

  // Scan phases, one-hot.
  typedef enum logic [11:0] {
    PH_IDLE  = 12'b0000_0000_0001,
    PH_ZERO  = 12'b0000_0000_0010,
    PH_DEC   = 12'b0000_0000_0100,
    PH_DOT   = 12'b0000_0000_1000,
    PH_FRAC  = 12'b0000_0001_0000,
    PH_EXPS  = 12'b0000_0010_0000,
    PH_EXPD  = 12'b0000_0100_0000,
    PH_HEX   = 12'b0000_1000_0000,
    PH_BIN   = 12'b0001_0000_0000,
    PH_OCT   = 12'b0010_0000_0000,
    PH_ISUF  = 12'b0100_0000_0000,
    PH_ISUFL = 12'b1000_0000_0000
  } phase_t;

  // Radix codes as reported on the result.
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  // Float suffix kinds.
  localparam logic [1:0] FSUF_NONE   = 2'd0;
  localparam logic [1:0] FSUF_SINGLE = 2'd1;
  localparam logic [1:0] FSUF_LONG   = 2'd2;

  // Long suffix counts.
  localparam logic [1:0] LONG_NONE   = 2'd0;
  localparam logic [1:0] LONG_SINGLE = 2'd1;
  localparam logic [1:0] LONG_DOUBLE = 2'd2;

  // Counts of bytes handed back to the source.
  localparam logic [1:0] RET_NONE = 2'd0;
  localparam logic [1:0] RET_ONE  = 2'd1;
  localparam logic [1:0] RET_TWO  = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  // Scanner state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  radix;
    logic [63:0] accum;
    logic        overflowed;
    logic        float_seen;
    logic        unsigned_seen;
    logic [1:0]  long_seen;
    logic        long_upper;
    logic        suffix_bad;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    phase:         PH_IDLE,
    radix:         RADIX_DEC,
    accum:         64'd0,
    overflowed:    1'b0,
    float_seen:    1'b0,
    unsigned_seen: 1'b0,
    long_seen:     LONG_NONE,
    long_upper:    1'b0,
    suffix_bad:    1'b0
  };

  // One scanned literal.
  typedef struct packed {
    logic        float_mark;
    logic [1:0]  radix_code;
    logic [63:0] int_value;
    logic        overflow;
    logic        unsigned_mark;
    logic [1:0]  long_count;
    logic        suffix_error;
    logic        single_precision;
    logic        long_double_error;
    logic [1:0]  bytes_returned;
  } scan_result_t;

endpackage

// File: design/c_number_literal_scanner_core.sv
// Top level of the C numeric literal scanner: request registers, state and result register.
//
// Usage: source bytes enter on the in_ channel, one request per byte, with
// in_end_of_text marking the end of the text (no byte carried then). Each
// request yields zero or one result request on the out_ channel: a scanned
// literal with its radix, value, suffix flags and the count of trailing bytes
// that the caller must feed again. A non-digit byte outside a literal comes
// back at once as a result with all fields zero and one byte returned.
// Flow: an accepted request is held in the request register, scanned from there,
// and its result, if any, is captured in the result register.
// Throughput: one byte per cycle while the receiver does not stall; the per-byte
// digit accumulate, a 68-bit shift-add with saturation check, sits between the
// request register and the scanner state register.
// When the receiver stalls, the result is held and the pending byte waits in
// the request register; in_stall rises only while both are occupied.
// Reset (synchronous, active low) empties both registers and returns the
// scanner to idle with a cleared value.
module c_number_literal_scanner_core import cnls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_float_mark,
  output logic [1:0]  out_radix_code,
  output logic [63:0] out_int_value,
  output logic        out_overflow,
  output logic        out_unsigned_mark,
  output logic [1:0]  out_long_count,
  output logic        out_suffix_error,
  output logic        out_single_precision,
  output logic        out_long_double_error,
  output logic [1:0]  out_bytes_returned
);

  logic         item_valid_r;
  logic [7:0]   item_char_r;
  logic         item_eot_r;
  scan_state_t  state_r;
  scan_state_t  state_nxt;
  logic         out_valid_r;
  scan_result_t out_res_r;
  scan_result_t step_res;
  logic         step_fire;
  logic         out_free;
  logic         proc;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_char_r <= in_char_byte;
      item_eot_r  <= in_end_of_text;
    end
  end

  // Scanner step for the registered byte.
  cnls_step u_step (
    .state_cur   (state_r),
    .char_byte   (item_char_r),
    .end_of_text (item_eot_r),
    .state_nxt   (state_nxt),
    .res_fire    (step_fire),
    .res         (step_res)
  );

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCAN_CLEAR;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc && step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && step_fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_float_mark        = out_res_r.float_mark;
  assign out_radix_code        = out_res_r.radix_code;
  assign out_int_value         = out_res_r.int_value;
  assign out_overflow          = out_res_r.overflow;
  assign out_unsigned_mark     = out_res_r.unsigned_mark;
  assign out_long_count        = out_res_r.long_count;
  assign out_suffix_error      = out_res_r.suffix_error;
  assign out_single_precision  = out_res_r.single_precision;
  assign out_long_double_error = out_res_r.long_double_error;
  assign out_bytes_returned    = out_res_r.bytes_returned;

endmodule

// File: design/cnls_step.sv
// Next-state and result logic of the scanner for one source byte.
module cnls_step import cnls_pkg::*; (
  input  scan_state_t  state_cur,
  input  logic [7:0]   char_byte,
  input  logic         end_of_text,
  output scan_state_t  state_nxt,
  output logic         res_fire,
  output scan_result_t res
);

  // Digit value of a hex character, 16 when it is none.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= CH_0 && c <= CH_9)       v = {1'b0, c[3:0]};
    else if (c >= CH_LO_A && c <= CH_LO_F) v = 5'(c - CH_LO_A + 8'd10);
    else if (c >= CH_UP_A && c <= CH_UP_F) v = 5'(c - CH_UP_A + 8'd10);
    return v;
  endfunction

  logic        is_dec;
  logic        is_e;
  logic        is_l;
  logic        is_up_l;
  logic        is_u;
  logic        is_f;
  logic [4:0]  hv;
  logic [67:0] acc_ext;
  logic [67:0] acc_mult;
  logic [67:0] acc_sum;
  logic [63:0] add_accum;
  logic        add_ovf;
  scan_state_t s;
  logic        dec_tail;
  logic        int_tail;
  logic        flt_tail;
  logic [1:0]  fsk;
  logic [1:0]  ret;

  // Character classes.
  assign is_dec  = (char_byte >= CH_0) && (char_byte <= CH_9);
  assign is_e    = (char_byte == CH_LO_E) || (char_byte == CH_UP_E);
  assign is_up_l = (char_byte == CH_UP_L);
  assign is_l    = (char_byte == CH_LO_L) || is_up_l;
  assign is_u    = (char_byte == CH_LO_U) || (char_byte == CH_UP_U);
  assign is_f    = (char_byte == CH_LO_F) || (char_byte == CH_UP_F);
  assign hv      = hex_val(char_byte);

  // Accumulate one digit: multiply by the radix with shifts, add, saturate past 64 bits.
  assign acc_ext = {4'd0, state_cur.accum};
  always_comb begin
    case (state_cur.phase)
      PH_DEC:  acc_mult = (acc_ext << 3) + (acc_ext << 1);
      PH_HEX:  acc_mult = acc_ext << 4;
      PH_BIN:  acc_mult = acc_ext << 1;
      default: acc_mult = acc_ext << 3;
    endcase
  end
  assign acc_sum = acc_mult + {64'd0, hv[3:0]};

  always_comb begin
    if (state_cur.overflowed) begin
      add_accum = state_cur.accum;
      add_ovf   = 1'b1;
    end else if (acc_sum[67:64] != 4'd0) begin
      add_accum = '1;
      add_ovf   = 1'b1;
    end else begin
      add_accum = acc_sum[63:0];
      add_ovf   = 1'b0;
    end
  end

  // Phase transitions and literal endings.
  always_comb begin
    s        = state_cur;
    res_fire = 1'b0;
    dec_tail = 1'b0;
    int_tail = 1'b0;
    flt_tail = 1'b0;
    fsk      = FSUF_NONE;
    ret      = RET_NONE;

    if (end_of_text) begin
      if (state_cur.phase != PH_IDLE) begin
        res_fire = 1'b1;
        ret      = (state_cur.phase == PH_DOT) ? RET_ONE : RET_NONE;
      end
    end else begin
      unique case (state_cur.phase) inside
        PH_IDLE: begin
          if (!is_dec) begin
            res_fire = 1'b1;
            ret      = RET_ONE;
          end else begin
            s = SCAN_CLEAR;
            if (char_byte == CH_0) begin
              s.phase = PH_ZERO;
            end else begin
              s.phase = PH_DEC;
              s.accum = {60'd0, char_byte[3:0]};
            end
          end
        end
        PH_ZERO: begin
          if (char_byte == CH_LO_X || char_byte == CH_UP_X) begin
            s.radix = RADIX_HEX;
            s.phase = PH_HEX;
          end else if (char_byte == CH_LO_B || char_byte == CH_UP_B) begin
            s.radix = RADIX_BIN;
            s.phase = PH_BIN;
          end else if (is_dec) begin
            s.radix = RADIX_OCT;
            if (char_byte <= CH_7) begin
              s.phase      = PH_OCT;
              s.accum      = add_accum;
              s.overflowed = add_ovf;
            end else begin
              res_fire = 1'b1;
              ret      = RET_ONE;
            end
          end else begin
            s.phase  = PH_DEC;
            dec_tail = 1'b1;
          end
        end
        PH_DEC: begin
          if (is_dec) begin
            s.accum      = add_accum;
            s.overflowed = add_ovf;
          end else begin
            dec_tail = 1'b1;
          end
        end
        PH_DOT: begin
          if (is_dec) begin
            s.float_seen = 1'b1;
            s.phase      = PH_FRAC;
          end else begin
            res_fire = 1'b1;
            ret      = RET_TWO;
          end
        end
        PH_FRAC: begin
          if (is_e) s.phase = PH_EXPS;
          else if (!is_dec) flt_tail = 1'b1;
        end
        PH_EXPS: begin
          if (is_dec || char_byte == CH_PLUS || char_byte == CH_MINUS) s.phase = PH_EXPD;
          else flt_tail = 1'b1;
        end
        PH_EXPD: begin
          if (!is_dec) flt_tail = 1'b1;
        end
        PH_HEX: begin
          if (!hv[4]) begin
            s.accum      = add_accum;
            s.overflowed = add_ovf;
          end else begin
            int_tail = 1'b1;
          end
        end
        PH_BIN: begin
          if (char_byte == CH_0 || char_byte == CH_1) begin
            s.accum      = add_accum;
            s.overflowed = add_ovf;
          end else begin
            int_tail = 1'b1;
          end
        end
        PH_OCT: begin
          if (char_byte >= CH_0 && char_byte <= CH_7) begin
            s.accum      = add_accum;
            s.overflowed = add_ovf;
          end else begin
            int_tail = 1'b1;
          end
        end
        PH_ISUF, PH_ISUFL: begin
          int_tail = 1'b1;
        end
        default: begin
          s = SCAN_CLEAR;
        end
      endcase

      // A non-digit after decimal digits: dot, exponent or suffix.
      if (dec_tail) begin
        if (char_byte == CH_DOT) begin
          s.phase = PH_DOT;
        end else if (is_e) begin
          s.float_seen = 1'b1;
          s.phase      = PH_EXPS;
        end else begin
          int_tail = 1'b1;
        end
      end

      // Integer suffix run; any other byte ends the literal and goes back.
      if (int_tail) begin
        if (is_u) begin
          if (!s.suffix_bad) begin
            if (s.unsigned_seen) s.suffix_bad = 1'b1;
            else s.unsigned_seen = 1'b1;
          end
          s.phase = PH_ISUF;
        end else if (is_l) begin
          if (!s.suffix_bad && state_cur.phase == PH_ISUFL && is_up_l == s.long_upper) begin
            s.long_seen = LONG_DOUBLE;
            s.phase     = PH_ISUF;
          end else if (!s.suffix_bad && s.long_seen == LONG_NONE) begin
            s.long_seen  = LONG_SINGLE;
            s.long_upper = is_up_l;
            s.phase      = PH_ISUFL;
          end else begin
            if (!s.suffix_bad) s.suffix_bad = 1'b1;
            s.phase = PH_ISUF;
          end
        end else begin
          res_fire = 1'b1;
          ret      = RET_ONE;
        end
      end

      // Float ending: an f or l suffix is consumed, anything else goes back.
      if (flt_tail) begin
        res_fire = 1'b1;
        if (is_f) begin
          fsk = FSUF_SINGLE;
          ret = RET_NONE;
        end else if (is_l) begin
          fsk = FSUF_LONG;
          ret = RET_NONE;
        end else begin
          ret = RET_ONE;
        end
      end
    end
  end

  // Result fields; a float reports no integer information.
  always_comb begin
    res.float_mark        = s.float_seen;
    res.radix_code        = s.float_seen ? RADIX_DEC : s.radix;
    res.int_value         = s.float_seen ? 64'd0 : (s.overflowed ? '1 : s.accum);
    res.overflow          = !s.float_seen && s.overflowed;
    res.unsigned_mark     = !s.float_seen && s.unsigned_seen;
    res.long_count        = s.float_seen ? LONG_NONE : s.long_seen;
    res.suffix_error      = !s.float_seen && s.suffix_bad;
    res.single_precision  = s.float_seen && (fsk == FSUF_SINGLE);
    res.long_double_error = s.float_seen && (fsk == FSUF_LONG);
    res.bytes_returned    = ret;
  end

  assign state_nxt = res_fire ? SCAN_CLEAR : s;

endmodule

// File: bench/cnls_literal_checker.sv
// Watches both channels of the numeric literal scanner, predicts each literal and compares it.
module cnls_literal_checker import cnls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_float_mark,
  input  logic [1:0]  out_radix_code,
  input  logic [63:0] out_int_value,
  input  logic        out_overflow,
  input  logic        out_unsigned_mark,
  input  logic [1:0]  out_long_count,
  input  logic        out_suffix_error,
  input  logic        out_single_precision,
  input  logic        out_long_double_error,
  input  logic [1:0]  out_bytes_returned,
  output int          mismatch_total,
  output int          literals_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] BASE_BIN = 5'd2;
  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;
  localparam logic [4:0] NOT_HEX  = 5'd16;

  // Scanner state as this side sees it.
  phase_t      lit_phase;
  logic [1:0]  lit_radix;
  logic [63:0] lit_accum;
  logic        lit_ovf;
  logic        lit_float;
  logic        lit_unsigned;
  logic [1:0]  lit_long;
  logic        lit_long_upper;
  logic        lit_sfx_bad;
  logic [1:0]  lit_fsuf;

  scan_result_t owed_literals[$];
  int           mismatches = 0;
  int           literals_seen = 0;

  initial begin
    mismatch_total = 0;
    literals_pending = 0;
  end

  task automatic clear_literal();
    lit_phase      = PH_IDLE;
    lit_radix      = RADIX_DEC;
    lit_accum      = '0;
    lit_ovf        = 1'b0;
    lit_float      = 1'b0;
    lit_unsigned   = 1'b0;
    lit_long       = LONG_NONE;
    lit_long_upper = 1'b0;
    lit_sfx_bad    = 1'b0;
    lit_fsuf       = FSUF_NONE;
  endtask

  initial clear_literal();

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (is_digit(c)) return 5'(c - CH_0);
    if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
    return NOT_HEX;
  endfunction

  // Multiply-add one digit; once the value leaves 64 bits it sticks at all ones.
  task automatic accumulate_digit(input logic [4:0] base, input logic [3:0] digit);
    logic [71:0] wide;
    if (!lit_ovf) begin
      wide = {8'd0, lit_accum} * base + digit;
      if (wide[71:64] != 8'd0) begin
        lit_ovf   = 1'b1;
        lit_accum = '1;
      end else begin
        lit_accum = wide[63:0];
      end
    end
  endtask

  // Close the current literal, queue what the block should report, and go idle.
  task automatic emit_literal(input logic [1:0] ret);
    scan_result_t r;
    r.float_mark        = lit_float;
    r.radix_code        = lit_float ? RADIX_DEC : lit_radix;
    r.int_value         = lit_float ? 64'd0 : (lit_ovf ? '1 : lit_accum);
    r.overflow          = !lit_float && lit_ovf;
    r.unsigned_mark     = !lit_float && lit_unsigned;
    r.long_count        = lit_float ? LONG_NONE : lit_long;
    r.suffix_error      = !lit_float && lit_sfx_bad;
    r.single_precision  = lit_float && (lit_fsuf == FSUF_SINGLE);
    r.long_double_error = lit_float && (lit_fsuf == FSUF_LONG);
    r.bytes_returned    = ret;
    owed_literals.push_back(r);
    clear_literal();
  endtask

  // Integer suffix run. Once the run has gone bad, bytes are swallowed but the
  // suffix fields stay frozen.
  function automatic bit take_int_suffix(logic [7:0] c);
    bit upper;
    if (c == CH_LO_U || c == CH_UP_U) begin
      if (!lit_sfx_bad) begin
        if (lit_unsigned) lit_sfx_bad = 1'b1;
        else lit_unsigned = 1'b1;
      end
      lit_phase = PH_ISUF;
      return 1'b1;
    end
    if (c == CH_LO_L || c == CH_UP_L) begin
      upper = (c == CH_UP_L);
      if (!lit_sfx_bad) begin
        if (lit_phase == PH_ISUFL && upper == lit_long_upper) begin
          lit_long  = LONG_DOUBLE;
          lit_phase = PH_ISUF;
          return 1'b1;
        end
        if (lit_long != LONG_NONE) begin
          lit_sfx_bad = 1'b1;
        end else begin
          lit_long       = LONG_SINGLE;
          lit_long_upper = upper;
          lit_phase      = PH_ISUFL;
          return 1'b1;
        end
      end
      lit_phase = PH_ISUF;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic end_integer(input logic [7:0] c);
    if (!take_int_suffix(c)) emit_literal(RET_ONE);
  endtask

  // A float suffix is eaten and closes the literal; any other byte goes back.
  task automatic end_float(input logic [7:0] c);
    logic [1:0] ret;
    ret = RET_ONE;
    if (c == CH_LO_F || c == CH_UP_F) begin
      lit_fsuf = FSUF_SINGLE;
      ret      = RET_NONE;
    end else if (c == CH_LO_L || c == CH_UP_L) begin
      lit_fsuf = FSUF_LONG;
      ret      = RET_NONE;
    end
    emit_literal(ret);
  endtask

  task automatic scan_decimal(input logic [7:0] c);
    if (is_digit(c)) begin
      accumulate_digit(BASE_DEC, 4'(c - CH_0));
    end else if (c == CH_DOT) begin
      lit_phase = PH_DOT;
    end else if (c == CH_LO_E || c == CH_UP_E) begin
      lit_float = 1'b1;
      lit_phase = PH_EXPS;
    end else begin
      end_integer(c);
    end
  endtask

  // Advance the scanner by one request.
  task automatic scan_byte(input logic [7:0] c, input logic eot);
    logic [4:0] hv;
    if (eot) begin
      // End of text closes an open literal; a held dot goes back with it.
      if (lit_phase != PH_IDLE) emit_literal(lit_phase == PH_DOT ? RET_ONE : RET_NONE);
    end else begin
      case (lit_phase)
        PH_IDLE: begin
          if (!is_digit(c)) begin
            emit_literal(RET_ONE);
          end else begin
            clear_literal();
            if (c == CH_0) begin
              lit_phase = PH_ZERO;
            end else begin
              lit_phase = PH_DEC;
              lit_accum = 64'(c - CH_0);
            end
          end
        end
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            lit_radix = RADIX_HEX;
            lit_phase = PH_HEX;
          end else if (c == CH_LO_B || c == CH_UP_B) begin
            lit_radix = RADIX_BIN;
            lit_phase = PH_BIN;
          end else if (is_digit(c)) begin
            // Octal; a leading 8 or 9 ends the literal right away.
            lit_radix = RADIX_OCT;
            if (c <= CH_7) begin
              lit_phase = PH_OCT;
              accumulate_digit(BASE_OCT, 4'(c - CH_0));
            end else begin
              emit_literal(RET_ONE);
            end
          end else begin
            lit_phase = PH_DEC;
            scan_decimal(c);
          end
        end
        PH_DEC: scan_decimal(c);
        PH_DOT: begin
          if (is_digit(c)) begin
            lit_float = 1'b1;
            lit_phase = PH_FRAC;
          end else begin
            emit_literal(RET_TWO);
          end
        end
        PH_FRAC: begin
          if (c == CH_LO_E || c == CH_UP_E) lit_phase = PH_EXPS;
          else if (!is_digit(c)) end_float(c);
        end
        PH_EXPS: begin
          if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) lit_phase = PH_EXPD;
          else end_float(c);
        end
        PH_EXPD: begin
          if (!is_digit(c)) end_float(c);
        end
        PH_HEX: begin
          hv = hex_value(c);
          if (hv != NOT_HEX) accumulate_digit(BASE_HEX, hv[3:0]);
          else end_integer(c);
        end
        PH_BIN: begin
          if (c == CH_0 || c == CH_1) accumulate_digit(BASE_BIN, 4'(c - CH_0));
          else end_integer(c);
        end
        PH_OCT: begin
          if (c >= CH_0 && c <= CH_7) accumulate_digit(BASE_OCT, 4'(c - CH_0));
          else end_integer(c);
        end
        default: end_integer(c);
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] literal %0d %s: got %0h, expected %0h",
             $realtime, literals_seen, what, got, want);
    mismatches++;
  endtask

  // Compare one accepted result with the oldest literal still owed.
  task automatic check_literal();
    scan_result_t got;
    scan_result_t want;
    got = {out_float_mark, out_radix_code, out_int_value, out_overflow, out_unsigned_mark,
           out_long_count, out_suffix_error, out_single_precision, out_long_double_error,
           out_bytes_returned};
    if (owed_literals.size() == 0) begin
      report_mismatch("arrived with none owed, int_value", got.int_value, 64'd0);
    end else begin
      want = owed_literals.pop_front();
      if (got.float_mark !== want.float_mark)
        report_mismatch("float_mark", 64'(got.float_mark), 64'(want.float_mark));
      if (got.radix_code !== want.radix_code)
        report_mismatch("radix_code", 64'(got.radix_code), 64'(want.radix_code));
      if (got.int_value !== want.int_value)
        report_mismatch("int_value", got.int_value, want.int_value);
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
      if (got.unsigned_mark !== want.unsigned_mark)
        report_mismatch("unsigned_mark", 64'(got.unsigned_mark), 64'(want.unsigned_mark));
      if (got.long_count !== want.long_count)
        report_mismatch("long_count", 64'(got.long_count), 64'(want.long_count));
      if (got.suffix_error !== want.suffix_error)
        report_mismatch("suffix_error", 64'(got.suffix_error), 64'(want.suffix_error));
      if (got.single_precision !== want.single_precision)
        report_mismatch("single_precision", 64'(got.single_precision),
                        64'(want.single_precision));
      if (got.long_double_error !== want.long_double_error)
        report_mismatch("long_double_error", 64'(got.long_double_error),
                        64'(want.long_double_error));
      if (got.bytes_returned !== want.bytes_returned)
        report_mismatch("bytes_returned", 64'(got.bytes_returned),
                        64'(want.bytes_returned));
    end
    literals_seen++;
  endtask

  // Results are checked before the new request is scanned; a request cannot
  // produce its result at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_literal();
      owed_literals.delete();
    end else begin
      if (out_valid && !out_stall) check_literal();
      if (in_valid && !in_stall) scan_byte(in_char_byte, in_end_of_text);
    end
    literals_pending <= owed_literals.size();
    mismatch_total   <= mismatches;
  end

endmodule

// File: bench/c_number_literal_scanner_core_tb.sv
// Stimulus, flow control and verdict for the numeric literal scanner testbench.
module c_number_literal_scanner_core_tb import cnls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_BYTES   = 850;
  localparam int MAX_WAIT     = 12;
  localparam int HOLD_CYCLES  = 150;
  localparam int RUSH_BYTES   = 60;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'd0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_float_mark;
  logic [1:0]  out_radix_code;
  logic [63:0] out_int_value;
  logic        out_overflow;
  logic        out_unsigned_mark;
  logic [1:0]  out_long_count;
  logic        out_suffix_error;
  logic        out_single_precision;
  logic        out_long_double_error;
  logic [1:0]  out_bytes_returned;
  int          mismatch_total;
  int          literals_pending;

  // Source text waiting to be sent: bit 8 marks end of text.
  logic [8:0] text_q[$];
  int         bytes_sent = 0;
  int         tx_rush = 0;
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  bit         rx_hold_req = 1'b0;
  int         quiet_cycles = 0;

  string int_suffixes [16] = '{"", "", "", "u", "U", "l", "L", "ul", "LU", "ull", "LLU",
                               "uLL", "uu", "lL", "lll", "Ll"};
  string separators = " ;,)";

  c_number_literal_scanner_core u_top (.*);

  cnls_literal_checker u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycles with no request moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall before each result, plus one long hold on request.
  initial begin
    int wait_n;
    forever begin
      if ($urandom_range(39, 0) == 0) rx_steady = !rx_steady;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_n = rx_steady ? 0 : $urandom_range(MAX_WAIT, 0);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic put_char(input logic [7:0] c);
    text_q.push_back({1'b0, c});
  endtask

  // The byte that rides along with end of text is ignored, so it is random.
  task automatic put_eot();
    text_q.push_back({1'b1, 8'($urandom_range(255, 0))});
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] dec_char();
    return CH_0 + 8'($urandom_range(9, 0));
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15, 0);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(1, 0) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
  endfunction

  // Mostly short digit runs, now and then a long one that can overflow.
  function automatic int pick_len(int short_max, int long_lo, int long_hi);
    if ($urandom_range(5, 0) == 0) return $urandom_range(long_hi, long_lo);
    return $urandom_range(short_max, 0);
  endfunction

  task automatic put_int_suffix();
    int k;
    k = $urandom_range(16, 0);
    if (k < 16) begin
      put_str(int_suffixes[k]);
    end else begin
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(3, 0))
          0: put_char(CH_LO_U);
          1: put_char(CH_UP_U);
          2: put_char(CH_LO_L);
          default: put_char(CH_UP_L);
        endcase
      end
    end
  endtask

  task automatic put_terminator();
    int k;
    k = $urandom_range(7, 0);
    if (k == 0) put_eot();
    else if (k <= 4) put_char(separators[k - 1]);
    else put_char(8'($urandom_range(255, 0)));
  endtask

  // One literal of a random kind followed by whatever ends it, or plain noise.
  task automatic make_literal();
    int form;
    case ($urandom_range(11, 0)) inside
      0, 1: begin
        put_char(CH_1 + 8'($urandom_range(8, 0)));
        repeat (pick_len(5, 17, 22)) put_char(dec_char());
        put_int_suffix();
        put_terminator();
      end
      2: begin
        // Right at the edge of 64 bits: the last digit decides saturation.
        put_str("1844674407370955161");
        put_char(CH_0 + 8'($urandom_range(7, 4)));
        put_int_suffix();
        put_terminator();
      end
      3: begin
        put_char(CH_0);
        put_char($urandom_range(1, 0) ? CH_LO_X : CH_UP_X);
        repeat (pick_len(6, 15, 18)) put_char(hex_char());
        put_int_suffix();
        put_terminator();
      end
      4: begin
        put_char(CH_0);
        put_char($urandom_range(1, 0) ? CH_LO_B : CH_UP_B);
        repeat (pick_len(8, 62, 66)) put_char(CH_0 + 8'($urandom_range(1, 0)));
        put_int_suffix();
        put_terminator();
      end
      5: begin
        put_char(CH_0);
        repeat (pick_len(5, 20, 24)) put_char(CH_0 + 8'($urandom_range(7, 0)));
        if ($urandom_range(3, 0) == 0) put_char(CH_9 - 8'($urandom_range(1, 0)));
        put_int_suffix();
        put_terminator();
      end
      6, 7, 8: begin
        // Float: fraction, exponent or both, then an optional suffix.
        repeat ($urandom_range(4, 1)) put_char(dec_char());
        form = $urandom_range(2, 0);
        if (form != 1) begin
          put_char(CH_DOT);
          repeat ($urandom_range(3, 1)) put_char(dec_char());
        end
        if (form != 0) begin
          put_char($urandom_range(1, 0) ? CH_LO_E : CH_UP_E);
          case ($urandom_range(2, 0))
            0: put_char(CH_PLUS);
            1: put_char(CH_MINUS);
            default: ;
          endcase
          repeat ($urandom_range(3, 0)) put_char(dec_char());
        end
        case ($urandom_range(5, 0))
          0: put_char(CH_LO_F);
          1: put_char(CH_UP_F);
          2: put_char(CH_LO_L);
          3: put_char(CH_UP_L);
          default: ;
        endcase
        put_terminator();
      end
      9: begin
        // A dot, usually with no digit after it, which then belongs to the next token.
        repeat ($urandom_range(3, 1)) put_char(dec_char());
        put_char(CH_DOT);
        put_terminator();
      end
      10: begin
        repeat ($urandom_range(4, 1)) put_char(8'($urandom_range(255, 0)));
      end
      default: begin
        // Broken literal: a bare prefix cut short by an arbitrary byte.
        case ($urandom_range(4, 0))
          0: put_str("0x");
          1: put_str("0B");
          2: put_str("1e");
          3: put_str("7.");
          default: put_char(CH_0);
        endcase
        put_char(8'($urandom_range(255, 0)));
      end
    endcase
  endtask

  // Offer one request and hold it until it is taken.
  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    if ($urandom_range(39, 0) == 0) tx_steady = !tx_steady;
    gap = (tx_rush > 0 || tx_steady) ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_byte   <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (tx_rush > 0) tx_rush--;
  endtask

  task automatic send_text();
    logic [8:0] item;
    while (text_q.size() > 0) begin
      item = text_q.pop_front();
      send_byte(item[7:0], item[8]);
    end
  endtask

  // Stop offering and wait until every literal owed has come out.
  task automatic drain_literals();
    in_valid <= 1'b0;
    do @(posedge clk); while (literals_pending != 0);
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text: end of text while idle, stray bytes, empty hex prefix,
    // octal cut by a 9, dangling dots, bare exponent, float and bad suffixes.
    put_eot();
    put_char(8'hFF);
    put_str("0x;");
    put_str("09");
    put_str("1.");
    put_char(8'h00);
    put_str("2e+;");
    put_str("3.5f");
    put_str("7uu ");
    put_str("0b1");
    put_eot();
    put_str("1.");
    put_eot();
    put_str("5lL;");
    send_text();

    // Random text, with one burst against a held-off receiver and one full drain.
    while (bytes_sent < TEXT_BYTES) begin
      if (!hold_done && bytes_sent > TEXT_BYTES / 3) begin
        rx_hold_req = 1'b1;
        tx_rush     = RUSH_BYTES;
        hold_done   = 1'b1;
      end
      if (!pause_done && bytes_sent > 2 * TEXT_BYTES / 3) begin
        drain_literals();
        pause_done = 1'b1;
      end
      make_literal();
      send_text();
    end
    put_eot();
    send_text();

    drain_literals();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/cnls_pkg.sv
design/cnls_step.sv
design/c_number_literal_scanner_core.sv
bench/cnls_literal_checker.sv
bench/c_number_literal_scanner_core_tb.sv
